/* rtl/core/planar_odometry_integrator_assert.svh */
// Assertion macros for the planar odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define POI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition never holds outside reset.
`define POI_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/poi_pkg.sv */
// Shared types, constants and the arctangent table of the odometry integrator.
`default_nettype none

package poi_pkg;

	localparam int LIN_W = 20;
	localparam int ANG_W = 19;
	localparam int DT_W = 20;
	localparam int Q_W = 16;
	localparam int TRIG_W = 34;
	localparam int ZANG_W = 33;
	localparam int ITER_W = 5;
	localparam int TAB_LEN = 24;
	localparam int STEP_W = 24;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

	localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
		30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
		30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
		30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
	};

	typedef struct packed {
		logic load;
		logic trig_start;
		logic trig_half;
		logic mul1;
		logic mul2;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic trig_done;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/poi_cordic.sv */
// Iterative rotation-mode CORDIC giving cosine and sine of a 32-bit binary angle.
`default_nettype none

module poi_cordic #(
	parameter int TRIG_ITERS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [31:0]                        angle,
	output logic                                    done,
	output logic signed [poi_pkg::TRIG_W-1:0]       cos_v,
	output logic signed [poi_pkg::TRIG_W-1:0]       sin_v
);

	import poi_pkg::*;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(TRIG_ITERS - 1);

	logic                      busy_q;
	logic                      done_q;
	logic                      neg_q;
	logic [ITER_W-1:0]         iter_q;
	logic signed [TRIG_W-1:0]  x_q;
	logic signed [TRIG_W-1:0]  y_q;
	logic signed [ZANG_W-1:0]  z_q;

	logic                      fold;
	logic [31:0]               afold;
	logic signed [TRIG_W-1:0]  xs;
	logic signed [TRIG_W-1:0]  ys;
	logic signed [ZANG_W-1:0]  at;

	always_comb begin
		afold = angle + 32'h4000_0000;
		fold = afold[31];
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = $signed({3'b000, ATAN_TAB[iter_q]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q <= fold;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= fold ? $signed({~angle[31], ~angle[31], angle[30:0]})
			            : $signed({angle[31], angle});
		end else if (busy_q) begin
			if (!z_q[ZANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

endmodule

`default_nettype wire

/* rtl/core/poi_dp.sv */
// Datapath of the odometry integrator: pose registers, products, CORDIC and result register.
`default_nettype none

module poi_dp #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 48,
	parameter int TRIG_ITERS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire poi_pkg::cmd_t                      cmd,
	output poi_pkg::sts_t                           sts,
	input  wire logic signed [poi_pkg::LIN_W-1:0]   lin_vel,
	input  wire logic signed [poi_pkg::ANG_W-1:0]   ang_vel,
	input  wire logic [poi_pkg::DT_W-1:0]           elapsed,
	output logic signed [POS_BITS-1:0]              pos_x,
	output logic signed [POS_BITS-1:0]              pos_y,
	output logic [ANGLE_BITS-1:0]                   yaw,
	output logic signed [poi_pkg::Q_W-1:0]          quat_z,
	output logic signed [poi_pkg::Q_W-1:0]          quat_w,
	output logic signed [poi_pkg::LIN_W-1:0]        echo_lin,
	output logic signed [poi_pkg::ANG_W-1:0]        echo_ang
);

	import poi_pkg::*;

	localparam int PROD_W = LIN_W + TRIG_W;
	localparam int PSH_W = PROD_W - 10;
	localparam int HPROD_W = ANG_W + DT_W + 1;
	localparam int HS = 36 - ANGLE_BITS;
	localparam logic signed [HPROD_W:0] HROUND = (HPROD_W + 1)'(1) <<< (HS - 1);
	localparam logic signed [63:0] PROUND = 64'sd1 <<< 39;
	localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS - 1){1'b1}}};
	localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS - 1){1'b0}}};
	localparam logic signed [TRIG_W-15:0] QMAX = (TRIG_W - 14)'(32767);
	localparam logic signed [TRIG_W-15:0] QMIN = -(TRIG_W - 14)'(32768);

	logic signed [LIN_W-1:0]    lin_q;
	logic signed [ANG_W-1:0]    ang_q;
	logic [DT_W-1:0]            dt_q;
	logic signed [POS_BITS-1:0] x_acc_q;
	logic signed [POS_BITS-1:0] y_acc_q;
	logic [ANGLE_BITS-1:0]      heading_q;

	logic signed [PROD_W-1:0]   prod_x_s1;
	logic signed [PROD_W-1:0]   prod_y_s1;
	logic signed [HPROD_W-1:0]  hprod_s1;
	logic signed [63:0]         px_s2;
	logic signed [63:0]         py_s2;

	logic signed [POS_BITS-1:0] pos_x_q;
	logic signed [POS_BITS-1:0] pos_y_q;
	logic [ANGLE_BITS-1:0]      yaw_q;
	logic signed [Q_W-1:0]      quat_z_q;
	logic signed [Q_W-1:0]      quat_w_q;
	logic signed [LIN_W-1:0]    echo_lin_q;
	logic signed [ANG_W-1:0]    echo_ang_q;

	logic                       trig_done;
	logic [31:0]                trig_angle;
	logic signed [TRIG_W-1:0]   cos_v;
	logic signed [TRIG_W-1:0]   sin_v;
	logic signed [DT_W:0]       dt_s;
	logic signed [63:0]         px_r;
	logic signed [63:0]         py_r;
	logic signed [HPROD_W:0]    hsum;
	logic signed [HPROD_W:0]    hsh;

	function automatic logic signed [POS_BITS-1:0] sat_add(
		input logic signed [POS_BITS-1:0] acc,
		input logic signed [STEP_W-1:0]   step
	);
		logic signed [POS_BITS:0] sum;
		sum = {acc[POS_BITS-1], acc} + {{(POS_BITS + 1 - STEP_W){step[STEP_W-1]}}, step};
		if (sum[POS_BITS] == sum[POS_BITS-1]) begin
			return sum[POS_BITS-1:0];
		end else if (sum[POS_BITS]) begin
			return POS_MIN;
		end else begin
			return POS_MAX;
		end
	endfunction

	function automatic logic signed [Q_W-1:0] to_q15(input logic signed [TRIG_W-1:0] v);
		logic signed [TRIG_W:0]   s;
		logic signed [TRIG_W-15:0] r;
		s = {v[TRIG_W-1], v} + (TRIG_W + 1)'(16384);
		r = s[TRIG_W:15];
		if (r > QMAX) begin
			return 16'sh7fff;
		end else if (r < QMIN) begin
			return 16'sh8000;
		end else begin
			return r[Q_W-1:0];
		end
	endfunction

	always_comb begin
		if (cmd.trig_half) begin
			trig_angle = 32'(heading_q) << (31 - ANGLE_BITS);
		end else begin
			trig_angle = 32'(heading_q) << (32 - ANGLE_BITS);
		end
		dt_s = $signed({1'b0, dt_q});
		px_r = px_s2 + PROUND;
		py_r = py_s2 + PROUND;
		hsum = {hprod_s1[HPROD_W-1], hprod_s1} + HROUND;
		hsh = hsum >>> HS;
	end

	poi_cordic #(
		.TRIG_ITERS(TRIG_ITERS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.trig_start),
		.angle(trig_angle),
		.done(trig_done),
		.cos_v(cos_v),
		.sin_v(sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			heading_q <= '0;
		end else if (cmd.upd) begin
			x_acc_q <= sat_add(x_acc_q, px_r[63:40]);
			y_acc_q <= sat_add(y_acc_q, py_r[63:40]);
			heading_q <= heading_q + hsh[ANGLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lin_q <= lin_vel;
			ang_q <= ang_vel;
			dt_q <= elapsed;
		end
		if (cmd.mul1) begin
			prod_x_s1 <= lin_q * cos_v;
			prod_y_s1 <= lin_q * sin_v;
			hprod_s1 <= ang_q * dt_s;
		end
		if (cmd.mul2) begin
			px_s2 <= $signed(prod_x_s1[PROD_W-1:10]) * dt_s;
			py_s2 <= $signed(prod_y_s1[PROD_W-1:10]) * dt_s;
		end
		if (cmd.out_load) begin
			pos_x_q <= x_acc_q;
			pos_y_q <= y_acc_q;
			yaw_q <= heading_q;
			quat_z_q <= to_q15(sin_v);
			quat_w_q <= to_q15(cos_v);
			echo_lin_q <= lin_q;
			echo_ang_q <= ang_q;
		end
	end

	assign sts.trig_done = trig_done;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign yaw = yaw_q;
	assign quat_z = quat_z_q;
	assign quat_w = quat_w_q;
	assign echo_lin = echo_lin_q;
	assign echo_ang = echo_ang_q;

endmodule

`default_nettype wire

/* rtl/core/poi_ctrl.sv */
// Controller state machine that sequences one odometry update and the result handshake.
`default_nettype none
`include "planar_odometry_integrator_assert.svh"

module poi_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output poi_pkg::cmd_t       cmd,
	input  wire poi_pkg::sts_t  sts
);

	import poi_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START1 = 4'd1;
	localparam logic [3:0] S_TRIG1  = 4'd2;
	localparam logic [3:0] S_MUL1   = 4'd3;
	localparam logic [3:0] S_MUL2   = 4'd4;
	localparam logic [3:0] S_UPD    = 4'd5;
	localparam logic [3:0] S_START2 = 4'd6;
	localparam logic [3:0] S_TRIG2  = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       m_tvalid_q;
	logic       trig_wait;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_START1;
				end
			end
			S_START1: begin
				cmd.trig_start = 1'b1;
				state_d = S_TRIG1;
			end
			S_TRIG1: begin
				if (sts.trig_done) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_START2;
			end
			S_START2: begin
				cmd.trig_start = 1'b1;
				cmd.trig_half = 1'b1;
				state_d = S_TRIG2;
			end
			S_TRIG2: begin
				cmd.trig_half = 1'b1;
				if (sts.trig_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.trig_half = 1'b1;
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign trig_wait = (state_q == S_TRIG1) || (state_q == S_TRIG2);

	`POI_ASSERT(a_out_free, cmd.out_load |-> (!m_tvalid_q || m_tready), "result overwritten")
	`POI_ASSERT(a_done_wait, sts.trig_done |-> trig_wait, "trig done out of turn")
	`POI_ASSERT(a_accept_start, (s_tvalid && s_tready) |=> (state_q == S_START1), "accept did not start")
	`POI_ASSERT_NEVER(a_start_busy, cmd.trig_start && trig_wait, "restart while busy")

endmodule

`default_nettype wire

/* rtl/core/planar_odometry_integrator.sv */
// Top level of the planar odometry integrator, a dead-reckoning pose accumulator.
// A new item is taken only when idle, after the last result has been loaded into the output register.
// Per item: load, CORDIC run, products, pose update, half-heading CORDIC run, then result load.
// Reset clears the pose to zero; the block is ready as soon as reset is released.
`default_nettype none

module planar_odometry_integrator #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 48,
	parameter int TRIG_ITERS = 16,
	localparam int M_FIELDS_W = 2 * POS_BITS + ANGLE_BITS + 2 * poi_pkg::Q_W
		+ poi_pkg::LIN_W + poi_pkg::ANG_W,
	localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// lin_vel, ang_vel, elapsed
	input  wire logic [63:0]         s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// pos_x, pos_y, yaw, quat_z, quat_w, echo_lin, echo_ang
	output logic [M_DATA_W-1:0]      m_tdata
);

	import poi_pkg::*;

	cmd_t                       cmd;
	sts_t                       sts;
	logic signed [POS_BITS-1:0] pos_x;
	logic signed [POS_BITS-1:0] pos_y;
	logic [ANGLE_BITS-1:0]      yaw;
	logic signed [Q_W-1:0]      quat_z;
	logic signed [Q_W-1:0]      quat_w;
	logic signed [LIN_W-1:0]    echo_lin;
	logic signed [ANG_W-1:0]    echo_ang;

	poi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd(cmd),
		.sts(sts)
	);

	poi_dp #(
		.ANGLE_BITS(ANGLE_BITS),
		.POS_BITS(POS_BITS),
		.TRIG_ITERS(TRIG_ITERS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.lin_vel($signed(s_tdata[LIN_W-1:0])),
		.ang_vel($signed(s_tdata[LIN_W+ANG_W-1:LIN_W])),
		.elapsed(s_tdata[LIN_W+ANG_W+DT_W-1:LIN_W+ANG_W]),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.yaw(yaw),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.echo_lin(echo_lin),
		.echo_ang(echo_ang)
	);

	assign m_tdata = M_DATA_W'({echo_ang, echo_lin, quat_w, quat_z, yaw, pos_y, pos_x});

endmodule

`default_nettype wire
